>>> src/owbm_pkg.sv
// ----------------------------------------------------------------------------
// owbm_pkg
// Shared types and constants of the 1-Wire bus master: command codes,
// register map and timing defaults.
// ----------------------------------------------------------------------------
`default_nettype none

package owbm_pkg;

  localparam int TIMER_BITS_DEF = 10;

  // command codes
  localparam logic [2:0] OP_NONE      = 3'd0;
  localparam logic [2:0] OP_RESET     = 3'd1;
  localparam logic [2:0] OP_WRITE     = 3'd2;
  localparam logic [2:0] OP_READ      = 3'd3;
  localparam logic [2:0] OP_CRC_FEED  = 3'd4;
  localparam logic [2:0] OP_CRC_CLEAR = 3'd5;

  // register indexes (byte address = 4 * index)
  localparam int          ADDR_BITS = 5;
  localparam logic [2:0] REG_RESET_LOW   = 3'd0;
  localparam logic [2:0] REG_PRES_WAIT   = 3'd1;
  localparam logic [2:0] REG_RESET_TAIL  = 3'd2;
  localparam logic [2:0] REG_SLOT_LEN    = 3'd3;
  localparam logic [2:0] REG_WR1_LOW     = 3'd4;
  localparam logic [2:0] REG_WR0_LOW     = 3'd5;
  localparam logic [2:0] REG_RD_LOW      = 3'd6;
  localparam logic [2:0] REG_RD_SAMPLE   = 3'd7;

  // timing defaults in microseconds
  localparam logic [9:0] RESET_LOW_DEF  = 10'd500;
  localparam logic [9:0] PRES_WAIT_DEF  = 10'd70;
  localparam logic [9:0] RESET_TAIL_DEF = 10'd430;
  localparam logic [7:0] SLOT_LEN_DEF   = 8'd65;
  localparam logic [7:0] WR1_LOW_DEF    = 8'd15;
  localparam logic [7:0] WR0_LOW_DEF    = 8'd60;
  localparam logic [7:0] RD_LOW_DEF     = 8'd5;
  localparam logic [7:0] RD_SAMPLE_DEF  = 8'd10;

  // Dallas/Maxim CRC8, reflected polynomial x^8+x^5+x^4+1
  localparam logic [7:0] CRC_POLY = 8'h8C;

  typedef struct packed {
    logic [9:0] reset_low_time;
    logic [9:0] presence_wait_time;
    logic [9:0] reset_tail_time;
    logic [7:0] slot_length;
    logic [7:0] write_one_low_time;
    logic [7:0] write_zero_low_time;
    logic [7:0] read_low_time;
    logic [7:0] read_sample_time;
  } cfg_t;

  typedef struct packed {
    logic       feed;
    logic       clear;
    logic [7:0] data;
  } crc_cmd_t;

endpackage

`default_nettype wire

>>> src/one_wire_bus_master_unit.sv
// ----------------------------------------------------------------------------
// one_wire_bus_master_unit
// 1-Wire bus master paced by a microsecond tick beat, with Dallas CRC8.
//
//   channel | direction | handshake           | payload
//   --------+-----------+---------------------+-----------------------------------
//   in      | sink      | in_valid / in_stall | operation, write_data, bus_level
//   out     | source    | out_valid/out_stall | bus_pull_low, busy_res, done_res,
//           |           |                     | presence, read_data, crc_value
//   apb     | slave     | psel/penable/pready | paddr, pwdata, prdata
//
// One tick beat is taken per clock while in_stall is low; its result appears in
// the output register the cycle after. The tick's sequencer update is one level
// of counter compare plus the byte-wide CRC step. in_stall rises only while the
// output register holds a beat that the sink stalls. Synchronous reset returns the
// sequencer to idle and the timing registers to their defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module one_wire_bus_master_unit #(
  parameter int TIMER_BITS = owbm_pkg::TIMER_BITS_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  // tick input
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire logic [2:0]                     operation,
  input  wire logic [7:0]                     write_data,
  input  wire logic                           bus_level,
  // result output
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output logic                                bus_pull_low,
  output logic                                busy_res,
  output logic                                done_res,
  output logic                                presence,
  output logic [7:0]                          read_data,
  output logic [7:0]                          crc_value,
  // configuration
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [owbm_pkg::ADDR_BITS-1:0] paddr,
  input  wire logic [31:0]                    pwdata,
  output logic      [31:0]                    prdata,
  output logic                                pready
);

  localparam logic [2:0] PH_IDLE     = 3'd0;
  localparam logic [2:0] PH_RST_LOW  = 3'd1;
  localparam logic [2:0] PH_RST_WAIT = 3'd2;
  localparam logic [2:0] PH_RST_TAIL = 3'd3;
  localparam logic [2:0] PH_WRITE    = 3'd4;
  localparam logic [2:0] PH_READ     = 3'd5;

  localparam int TW = TIMER_BITS + 1;

  owbm_pkg::cfg_t     cfg;
  owbm_pkg::crc_cmd_t crc_cmd;
  logic [7:0]         crc;
  logic [7:0]         crc_next;

  logic                  accept;
  logic [2:0]            phase, phase_next;
  logic [TIMER_BITS-1:0] slot_timer, slot_timer_next;
  logic [2:0]            bit_index, bit_index_next;
  logic [7:0]            shift_byte, shift_byte_next;
  logic                  presence_flag, presence_flag_next;
  logic [7:0]            last_read, last_read_next;
  logic                  pull, busy, done;

  logic [TW-1:0]         timer_inc;
  logic [9:0]            rst_low_lim, rst_tail_lim;
  logic [7:0]            slot, samp, low_t;
  logic                  slot_last;

  owbm_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  assign crc_cmd.feed  = accept && (phase == PH_IDLE) && (operation == owbm_pkg::OP_CRC_FEED);
  assign crc_cmd.clear = accept && (phase == PH_IDLE) && (operation == owbm_pkg::OP_CRC_CLEAR);
  assign crc_cmd.data  = write_data;

  owbm_crc u_crc (
    .clk      (clk),
    .rst      (rst),
    .cmd      (crc_cmd),
    .crc      (crc),
    .crc_next (crc_next)
  );

  assign in_stall = out_valid && out_stall;
  assign accept   = in_valid && !in_stall;

  // zero reset-low, reset-tail and slot lengths count as one tick
  assign rst_low_lim  = (cfg.reset_low_time  == 10'd0) ? 10'd1 : cfg.reset_low_time;
  assign rst_tail_lim = (cfg.reset_tail_time == 10'd0) ? 10'd1 : cfg.reset_tail_time;
  assign slot         = (cfg.slot_length     == 8'd0)  ? 8'd1  : cfg.slot_length;
  assign samp         = (cfg.read_sample_time < slot) ? cfg.read_sample_time : slot - 8'd1;

  always_comb begin
    phase_next         = phase;
    slot_timer_next    = slot_timer;
    bit_index_next     = bit_index;
    shift_byte_next    = shift_byte;
    presence_flag_next = presence_flag;
    last_read_next     = last_read;
    pull               = 1'b0;
    busy               = 1'b0;
    done               = 1'b0;
    low_t              = 8'd0;
    slot_last          = 1'b0;
    timer_inc          = '0;

    // command start, only when idle
    if (phase == PH_IDLE) begin
      unique case (operation) inside
        owbm_pkg::OP_RESET: begin
          phase_next      = PH_RST_LOW;
          slot_timer_next = '0;
        end
        owbm_pkg::OP_WRITE: begin
          phase_next      = PH_WRITE;
          shift_byte_next = write_data;
          bit_index_next  = 3'd0;
          slot_timer_next = '0;
        end
        owbm_pkg::OP_READ: begin
          phase_next      = PH_READ;
          shift_byte_next = 8'd0;
          bit_index_next  = 3'd0;
          slot_timer_next = '0;
        end
        owbm_pkg::OP_CRC_FEED, owbm_pkg::OP_CRC_CLEAR: begin
          done = 1'b1;
        end
        default: begin
        end
      endcase
    end

    timer_inc = {1'b0, slot_timer_next} + TW'(1);
    slot_last = timer_inc >= TW'(slot);

    if (phase_next != PH_IDLE) begin
      busy = 1'b1;
      unique case (phase_next)
        PH_RST_LOW: begin
          pull = 1'b1;
          if (timer_inc >= TW'(rst_low_lim)) begin
            phase_next      = PH_RST_WAIT;
            slot_timer_next = '0;
          end else begin
            slot_timer_next = timer_inc[TIMER_BITS-1:0];
          end
        end
        PH_RST_WAIT: begin
          if (slot_timer_next >= TIMER_BITS'(cfg.presence_wait_time)) begin
            slot_timer_next = '0;
            if (!bus_level) begin
              presence_flag_next = 1'b1;
              phase_next         = PH_RST_TAIL;
            end else begin
              presence_flag_next = 1'b0;
              phase_next         = PH_IDLE;
              done               = 1'b1;
            end
          end else begin
            slot_timer_next = timer_inc[TIMER_BITS-1:0];
          end
        end
        PH_RST_TAIL: begin
          if (timer_inc >= TW'(rst_tail_lim)) begin
            slot_timer_next = '0;
            phase_next      = PH_IDLE;
            done            = 1'b1;
          end else begin
            slot_timer_next = timer_inc[TIMER_BITS-1:0];
          end
        end
        PH_WRITE: begin
          low_t = shift_byte_next[bit_index_next] ? cfg.write_one_low_time
                                                  : cfg.write_zero_low_time;
          pull  = slot_timer_next < TIMER_BITS'(low_t);
        end
        default: begin
          pull = slot_timer_next < TIMER_BITS'(cfg.read_low_time);
          if (slot_timer_next == TIMER_BITS'(samp)) begin
            shift_byte_next[bit_index_next] = bus_level;
          end
        end
      endcase

      // shared slot end for write and read
      if (phase_next == PH_WRITE || phase_next == PH_READ) begin
        if (slot_last) begin
          slot_timer_next = '0;
          if (bit_index_next == 3'd7) begin
            bit_index_next = 3'd0;
            if (phase_next == PH_READ) begin
              last_read_next = shift_byte_next;
            end
            phase_next = PH_IDLE;
            done       = 1'b1;
          end else begin
            bit_index_next = bit_index_next + 3'd1;
          end
        end else begin
          slot_timer_next = timer_inc[TIMER_BITS-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      slot_timer    <= '0;
      bit_index     <= 3'd0;
      shift_byte    <= 8'd0;
      presence_flag <= 1'b0;
      last_read     <= 8'd0;
      out_valid     <= 1'b0;
    end else begin
      if (accept) begin
        phase         <= phase_next;
        slot_timer    <= slot_timer_next;
        bit_index     <= bit_index_next;
        shift_byte    <= shift_byte_next;
        presence_flag <= presence_flag_next;
        last_read     <= last_read_next;
        out_valid     <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // result register, payload only
  always_ff @(posedge clk) begin
    if (accept) begin
      bus_pull_low <= pull;
      busy_res     <= busy;
      done_res     <= done;
      presence     <= presence_flag_next;
      read_data    <= last_read_next;
      crc_value    <= crc_next;
    end
  end

endmodule

`default_nettype wire

>>> src/owbm_regs.sv
// ----------------------------------------------------------------------------
// owbm_regs
// APB register file holding the bus timing values.
// ----------------------------------------------------------------------------
`default_nettype none

module owbm_regs (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [owbm_pkg::ADDR_BITS-1:0] paddr,
  input  wire logic [31:0]                    pwdata,
  output logic      [31:0]                    prdata,
  output logic                                pready,
  output owbm_pkg::cfg_t                      cfg
);

  logic       wr_en;
  logic [2:0] idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = paddr[4:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.reset_low_time      <= owbm_pkg::RESET_LOW_DEF;
      cfg.presence_wait_time  <= owbm_pkg::PRES_WAIT_DEF;
      cfg.reset_tail_time     <= owbm_pkg::RESET_TAIL_DEF;
      cfg.slot_length         <= owbm_pkg::SLOT_LEN_DEF;
      cfg.write_one_low_time  <= owbm_pkg::WR1_LOW_DEF;
      cfg.write_zero_low_time <= owbm_pkg::WR0_LOW_DEF;
      cfg.read_low_time       <= owbm_pkg::RD_LOW_DEF;
      cfg.read_sample_time    <= owbm_pkg::RD_SAMPLE_DEF;
    end else if (wr_en) begin
      unique case (idx)
        owbm_pkg::REG_RESET_LOW:  cfg.reset_low_time      <= pwdata[9:0];
        owbm_pkg::REG_PRES_WAIT:  cfg.presence_wait_time  <= pwdata[9:0];
        owbm_pkg::REG_RESET_TAIL: cfg.reset_tail_time     <= pwdata[9:0];
        owbm_pkg::REG_SLOT_LEN:   cfg.slot_length         <= pwdata[7:0];
        owbm_pkg::REG_WR1_LOW:    cfg.write_one_low_time  <= pwdata[7:0];
        owbm_pkg::REG_WR0_LOW:    cfg.write_zero_low_time <= pwdata[7:0];
        owbm_pkg::REG_RD_LOW:     cfg.read_low_time       <= pwdata[7:0];
        owbm_pkg::REG_RD_SAMPLE:  cfg.read_sample_time    <= pwdata[7:0];
        default:                  cfg.reset_low_time      <= pwdata[9:0];
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      owbm_pkg::REG_RESET_LOW:  prdata = {22'd0, cfg.reset_low_time};
      owbm_pkg::REG_PRES_WAIT:  prdata = {22'd0, cfg.presence_wait_time};
      owbm_pkg::REG_RESET_TAIL: prdata = {22'd0, cfg.reset_tail_time};
      owbm_pkg::REG_SLOT_LEN:   prdata = {24'd0, cfg.slot_length};
      owbm_pkg::REG_WR1_LOW:    prdata = {24'd0, cfg.write_one_low_time};
      owbm_pkg::REG_WR0_LOW:    prdata = {24'd0, cfg.write_zero_low_time};
      owbm_pkg::REG_RD_LOW:     prdata = {24'd0, cfg.read_low_time};
      owbm_pkg::REG_RD_SAMPLE:  prdata = {24'd0, cfg.read_sample_time};
      default:                  prdata = 32'd0;
    endcase
  end

endmodule

`default_nettype wire

>>> src/owbm_crc.sv
// ----------------------------------------------------------------------------
// owbm_crc
// Dallas CRC8 register: byte-wide feed or clear, one byte per beat.
// ----------------------------------------------------------------------------
`default_nettype none

module owbm_crc (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire owbm_pkg::crc_cmd_t cmd,
  output logic [7:0]              crc,
  output logic [7:0]              crc_next
);

  function automatic logic [7:0] crc8_byte(input logic [7:0] c_in, input logic [7:0] d_in);
    logic [7:0] c;
    logic [7:0] d;
    logic       mix;
    c = c_in;
    d = d_in;
    for (int i = 0; i < 8; i++) begin
      mix = c[0] ^ d[0];
      c   = c >> 1;
      if (mix) begin
        c = c ^ owbm_pkg::CRC_POLY;
      end
      d = d >> 1;
    end
    return c;
  endfunction

  always_comb begin
    if (cmd.clear) begin
      crc_next = 8'd0;
    end else if (cmd.feed) begin
      crc_next = crc8_byte(crc, cmd.data);
    end else begin
      crc_next = crc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      crc <= 8'd0;
    end else begin
      crc <= crc_next;
    end
  end

endmodule

`default_nettype wire

>>> src/owbm_checker.sv
// ----------------------------------------------------------------------------
// owbm_checker
// Port-level checks of the 1-Wire bus master, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module owbm_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       in_stall,
  input wire logic       out_valid,
  input wire logic       out_stall,
  input wire logic       bus_pull_low,
  input wire logic       busy_res,
  input wire logic       done_res,
  input wire logic [7:0] read_data,
  input wire logic [7:0] crc_value
);

  // input side only backs up behind a stalled result beat
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (out_valid && out_stall))
    else $error("in_stall without a stalled result beat");

  // the line is only driven during a bus command
  a_pull_busy: assert property (@(posedge clk) disable iff (rst)
    (out_valid && bus_pull_low) |-> busy_res)
    else $error("bus driven low outside a command");

  // a CRC command completes without driving the bus
  a_crc_done: assert property (@(posedge clk) disable iff (rst)
    (out_valid && done_res && !busy_res) |-> !bus_pull_low)
    else $error("idle done beat drives the bus");

  // reset empties the result register
  a_reset: assert property (@(posedge clk)
    rst |=> (!out_valid && !in_stall))
    else $error("result register not empty after reset");

  // stalled result beat holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(read_data) && $stable(crc_value)))
    else $error("stalled result beat changed");

endmodule

bind one_wire_bus_master_unit owbm_checker u_owbm_checker (
  .clk          (clk),
  .rst          (rst),
  .in_stall     (in_stall),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .bus_pull_low (bus_pull_low),
  .busy_res     (busy_res),
  .done_res     (done_res),
  .read_data    (read_data),
  .crc_value    (crc_value)
);

`default_nettype wire

>>> tb/tb_one_wire_bus_master_unit.sv
// ----------------------------------------------------------------------------
// tb_one_wire_bus_master_unit
// Self-checking bench for the 1-Wire bus master. Tick beats (command, data,
// sampled line level) go in with random bursts and gaps. Every result beat
// is checked field by field against a cycle-exact model of the sequencer and
// CRC8 in the scoreboard. Timing registers are reloaded over APB between
// phases: extremes first, then mostly short timings.
// ----------------------------------------------------------------------------
module tb_one_wire_bus_master_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [2:0]  OP_SPARE_LO = 3'd6;
  localparam logic [2:0]  OP_SPARE_HI = 3'd7;
  localparam int unsigned TMR_MASK    = (1 << owbm_pkg::TIMER_BITS_DEF) - 1;
  localparam int unsigned ITEM_TARGET = 800;

  // line level behavior while a command runs
  localparam int LV_LOW  = 0;
  localparam int LV_HIGH = 1;
  localparam int LV_RAND = 2;

  // timing register sets
  localparam int TM_ZERO  = 0;
  localparam int TM_ONE   = 1;
  localparam int TM_SHORT = 2;

  typedef enum logic [2:0] {
    SEQ_IDLE, SEQ_RST_LOW, SEQ_RST_WAIT, SEQ_RST_TAIL, SEQ_WRITE, SEQ_READ
  } seq_phase_t;

  typedef struct packed {
    logic       pull;
    logic       busy;
    logic       done;
    logic       pres;
    logic [7:0] rd_byte;
    logic [7:0] crc;
  } tick_result_t;

  class owire_scoreboard_t;
    logic [9:0]   low_us, wait_us, tail_us;
    logic [7:0]   slot_us, one_low_us, zero_low_us, rd_low_us, rd_sample_us;
    seq_phase_t   phase;
    int unsigned  tmr;
    int unsigned  bit_idx;
    logic [7:0]   shreg, last_byte, crc;
    logic         pres;
    tick_result_t ticks_due[$];
    int unsigned  errors;

    function new();
      low_us       = owbm_pkg::RESET_LOW_DEF;
      wait_us      = owbm_pkg::PRES_WAIT_DEF;
      tail_us      = owbm_pkg::RESET_TAIL_DEF;
      slot_us      = owbm_pkg::SLOT_LEN_DEF;
      one_low_us   = owbm_pkg::WR1_LOW_DEF;
      zero_low_us  = owbm_pkg::WR0_LOW_DEF;
      rd_low_us    = owbm_pkg::RD_LOW_DEF;
      rd_sample_us = owbm_pkg::RD_SAMPLE_DEF;
      phase        = SEQ_IDLE;
      tmr          = 0;
      bit_idx      = 0;
      shreg        = '0;
      last_byte    = '0;
      crc          = '0;
      pres         = 1'b0;
      errors       = 0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [31:0] v);
      case (idx)
        owbm_pkg::REG_RESET_LOW:  low_us       = v[9:0];
        owbm_pkg::REG_PRES_WAIT:  wait_us      = v[9:0];
        owbm_pkg::REG_RESET_TAIL: tail_us      = v[9:0];
        owbm_pkg::REG_SLOT_LEN:   slot_us      = v[7:0];
        owbm_pkg::REG_WR1_LOW:    one_low_us   = v[7:0];
        owbm_pkg::REG_WR0_LOW:    zero_low_us  = v[7:0];
        owbm_pkg::REG_RD_LOW:     rd_low_us    = v[7:0];
        default:                  rd_sample_us = v[7:0];
      endcase
    endfunction

    function int unsigned nonzero(int unsigned v);
      return (v == 0) ? 1 : v;
    endfunction

    function logic [7:0] crc8_byte(logic [7:0] c, logic [7:0] d);
      logic mix;
      for (int i = 0; i < 8; i++) begin
        mix = c[0] ^ d[0];
        c = c >> 1;
        if (mix) c = c ^ owbm_pkg::CRC_POLY;
        d = d >> 1;
      end
      return c;
    endfunction

    // closes one bit slot, returns 1 after the eighth
    function bit slot_over();
      tmr = 0;
      if (bit_idx >= 7) begin
        bit_idx = 0;
        phase = SEQ_IDLE;
        return 1'b1;
      end
      bit_idx++;
      return 1'b0;
    endfunction

    function bit busy();
      return phase != SEQ_IDLE;
    endfunction

    function void note_tick(logic [2:0] op, logic [7:0] wd, logic lvl);
      tick_result_t r;
      int unsigned  slot, samp, lowt;
      r = '0;
      slot = nonzero(slot_us);
      // a new command only starts from idle, and its phase runs from this tick
      if (phase == SEQ_IDLE) begin
        case (op)
          owbm_pkg::OP_RESET: begin
            phase = SEQ_RST_LOW;
            tmr = 0;
          end
          owbm_pkg::OP_WRITE: begin
            phase = SEQ_WRITE;
            shreg = wd;
            bit_idx = 0;
            tmr = 0;
          end
          owbm_pkg::OP_READ: begin
            phase = SEQ_READ;
            shreg = '0;
            bit_idx = 0;
            tmr = 0;
          end
          owbm_pkg::OP_CRC_FEED: begin
            crc = crc8_byte(crc, wd);
            r.done = 1'b1;
          end
          owbm_pkg::OP_CRC_CLEAR: begin
            crc = '0;
            r.done = 1'b1;
          end
          default: ;
        endcase
      end
      if (phase != SEQ_IDLE) begin
        r.busy = 1'b1;
        case (phase)
          SEQ_RST_LOW: begin
            r.pull = 1'b1;
            if (tmr + 1 >= nonzero(low_us)) begin
              phase = SEQ_RST_WAIT;
              tmr = 0;
            end else begin
              tmr = (tmr + 1) & TMR_MASK;
            end
          end
          SEQ_RST_WAIT: begin
            if (tmr >= wait_us) begin
              tmr = 0;
              pres = !lvl;
              if (lvl) begin
                // nobody answered: reset ends on the sample tick
                phase = SEQ_IDLE;
                r.done = 1'b1;
              end else begin
                phase = SEQ_RST_TAIL;
              end
            end else begin
              tmr = (tmr + 1) & TMR_MASK;
            end
          end
          SEQ_RST_TAIL: begin
            if (tmr + 1 >= nonzero(tail_us)) begin
              tmr = 0;
              phase = SEQ_IDLE;
              r.done = 1'b1;
            end else begin
              tmr = (tmr + 1) & TMR_MASK;
            end
          end
          SEQ_WRITE: begin
            lowt = shreg[bit_idx] ? one_low_us : zero_low_us;
            r.pull = tmr < lowt;
            if (tmr + 1 >= slot) begin
              if (slot_over()) r.done = 1'b1;
            end else begin
              tmr = (tmr + 1) & TMR_MASK;
            end
          end
          default: begin
            // sample point clamps to the last tick of the slot
            samp = (rd_sample_us < slot) ? rd_sample_us : slot - 1;
            r.pull = tmr < rd_low_us;
            if (tmr == samp) shreg[bit_idx] = shreg[bit_idx] | lvl;
            if (tmr + 1 >= slot) begin
              if (slot_over()) begin
                last_byte = shreg;
                r.done = 1'b1;
              end
            end else begin
              tmr = (tmr + 1) & TMR_MASK;
            end
          end
        endcase
      end
      r.pres = pres;
      r.rd_byte = last_byte;
      r.crc = crc;
      ticks_due.push_back(r);
    endfunction

    function void compare(string field, int unsigned want, int unsigned got);
      if (want != got) begin
        errors++;
        $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
      end
    endfunction

    function void check_tick(tick_result_t got);
      tick_result_t want;
      if (ticks_due.size() == 0) begin
        errors++;
        $display("%0t ns: result beat with none expected, actual %h", $time, got);
        return;
      end
      want = ticks_due.pop_front();
      compare("bus_pull_low", want.pull, got.pull);
      compare("busy_res", want.busy, got.busy);
      compare("done_res", want.done, got.done);
      compare("presence", want.pres, got.pres);
      compare("read_data", want.rd_byte, got.rd_byte);
      compare("crc_value", want.crc, got.crc);
    endfunction
  endclass

  logic                           clk = 1'b0;
  logic                           rst = 1'b1;
  logic                           in_valid = 1'b0;
  logic                           in_stall;
  logic [2:0]                     operation = owbm_pkg::OP_NONE;
  logic [7:0]                     write_data = '0;
  logic                           bus_level = 1'b1;
  logic                           out_valid;
  logic                           out_stall = 1'b0;
  logic                           bus_pull_low, busy_res, done_res, presence;
  logic [7:0]                     read_data, crc_value;
  logic                           psel = 1'b0;
  logic                           penable = 1'b0;
  logic                           pwrite = 1'b0;
  logic [owbm_pkg::ADDR_BITS-1:0] paddr = '0;
  logic [31:0]                    pwdata = '0;
  logic [31:0]                    prdata;
  logic                           pready;

  owire_scoreboard_t sb = new();

  int          gap_max = 0;
  int          burst_left = 0;
  int          stall_style = 0;
  int unsigned stall_cnt = 0;
  int unsigned ticks_sent = 0;

  one_wire_bus_master_unit uut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .operation    (operation),
    .write_data   (write_data),
    .bus_level    (bus_level),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .bus_pull_low (bus_pull_low),
    .busy_res     (busy_res),
    .done_res     (done_res),
    .presence     (presence),
    .read_data    (read_data),
    .crc_value    (crc_value),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // result side: stall pattern changes per phase
  always @(posedge clk) begin
    stall_cnt <= stall_cnt + 1;
    case (stall_style)
      1:       out_stall <= ($urandom_range(0, 3) == 0);
      2:       out_stall <= (stall_cnt % 9) < 4;
      default: out_stall <= 1'b0;
    endcase
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      sb.check_tick({bus_pull_low, busy_res, done_res, presence, read_data, crc_value});
  end

  function automatic logic level_for(int mode);
    if (mode == LV_LOW) return 1'b0;
    if (mode == LV_HIGH) return 1'b1;
    return 1'($urandom);
  endfunction

  function automatic logic [31:0] timing_value(int kind, bit wide);
    case (kind)
      TM_ZERO: return 32'd0;
      TM_ONE:  return 32'd1;
      default: return wide ? $urandom_range(0, 24) : $urandom_range(0, 12);
    endcase
  endfunction

  // one tick beat; bursts and gaps are decided here, never from the stall
  task automatic send_tick(input logic [2:0] op, input logic [7:0] wd, input logic lvl);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 48);
      gap = (gap_max == 0) ? 0 : $urandom_range(1, gap_max);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_valid   <= 1'b1;
    operation  <= op;
    write_data <= wd;
    bus_level  <= lvl;
    do @(posedge clk); while (in_stall);
    sb.note_tick(op, wd, lvl);
    ticks_sent++;
    burst_left--;
  endtask

  // command beat, then filler beats until done; commands sent while busy are noise
  task automatic run_command(input logic [2:0] op, input logic [7:0] wd, input int mode);
    send_tick(op, wd, level_for(mode));
    while (sb.busy())
      send_tick(($urandom_range(0, 3) == 0) ? 3'($urandom) : owbm_pkg::OP_NONE, 8'($urandom),
                level_for(mode));
    repeat ($urandom_range(0, 2)) send_tick(owbm_pkg::OP_NONE, 8'($urandom), 1'($urandom));
  endtask

  task automatic random_command();
    int          r;
    int          mode;
    logic [2:0]  op;
    r = $urandom_range(0, 99);
    if (r < 20)      op = owbm_pkg::OP_RESET;
    else if (r < 45) op = owbm_pkg::OP_WRITE;
    else if (r < 70) op = owbm_pkg::OP_READ;
    else if (r < 85) op = owbm_pkg::OP_CRC_FEED;
    else if (r < 92) op = owbm_pkg::OP_CRC_CLEAR;
    else if (r < 96) op = $urandom_range(0, 1) ? OP_SPARE_HI : OP_SPARE_LO;
    else             op = owbm_pkg::OP_NONE;
    r = $urandom_range(0, 4);
    mode = (r == 0) ? LV_LOW : (r == 1) ? LV_HIGH : LV_RAND;
    run_command(op, 8'($urandom), mode);
  endtask

  task automatic reg_write(input logic [2:0] idx, input logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.write_reg(idx, val);
  endtask

  // only called with the block idle and every result beat returned
  task automatic program_timing(input int kind);
    reg_write(owbm_pkg::REG_RESET_LOW, timing_value(kind, 1'b1));
    reg_write(owbm_pkg::REG_PRES_WAIT, timing_value(kind, 1'b1));
    reg_write(owbm_pkg::REG_RESET_TAIL, timing_value(kind, 1'b1));
    reg_write(owbm_pkg::REG_SLOT_LEN, timing_value(kind, 1'b0));
    reg_write(owbm_pkg::REG_WR1_LOW, timing_value(kind, 1'b0));
    reg_write(owbm_pkg::REG_WR0_LOW, timing_value(kind, 1'b0));
    reg_write(owbm_pkg::REG_RD_LOW, timing_value(kind, 1'b0));
    reg_write(owbm_pkg::REG_RD_SAMPLE, timing_value(kind, 1'b0));
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (sb.ticks_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  initial begin
    int k;
    int n;
    int kind;
    int waited;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // directed: CRC and spare codes on power-on timing
    gap_max = 3;
    stall_style = 1;
    run_command(owbm_pkg::OP_CRC_CLEAR, 8'h00, LV_RAND);
    run_command(owbm_pkg::OP_CRC_FEED, 8'h00, LV_RAND);
    run_command(owbm_pkg::OP_CRC_FEED, 8'hFF, LV_RAND);
    run_command(owbm_pkg::OP_CRC_FEED, 8'hA5, LV_RAND);
    run_command(OP_SPARE_LO, 8'h3C, LV_RAND);
    run_command(OP_SPARE_HI, 8'hC3, LV_RAND);
    run_command(owbm_pkg::OP_NONE, 8'h81, LV_RAND);

    // directed: bus commands on one-tick timing
    settle();
    program_timing(TM_ONE);
    run_command(owbm_pkg::OP_RESET, 8'h00, LV_LOW);
    run_command(owbm_pkg::OP_RESET, 8'h00, LV_HIGH);
    run_command(owbm_pkg::OP_WRITE, 8'h00, LV_HIGH);
    run_command(owbm_pkg::OP_WRITE, 8'hFF, LV_HIGH);
    run_command(owbm_pkg::OP_WRITE, 8'h5A, LV_RAND);
    run_command(owbm_pkg::OP_READ, 8'h00, LV_LOW);
    run_command(owbm_pkg::OP_READ, 8'hFF, LV_HIGH);
    run_command(owbm_pkg::OP_READ, 8'h00, LV_RAND);
    run_command(owbm_pkg::OP_CRC_FEED, 8'h5A, LV_RAND);

    // random phases until the tick budget is spent
    k = 0;
    while (ticks_sent < ITEM_TARGET) begin
      kind = (k == 0) ? TM_ZERO : (k % 4 == 3) ? TM_ONE : TM_SHORT;
      n = $urandom_range(4, 12);
      settle();
      program_timing(kind);
      gap_max = $urandom_range(0, 1) ? 0 : $urandom_range(1, 6);
      stall_style = $urandom_range(0, 2);
      repeat (n) begin
        if (ticks_sent < ITEM_TARGET) random_command();
      end
      k++;
    end

    in_valid <= 1'b0;
    stall_style = 0;
    waited = 0;
    while (sb.ticks_due.size() != 0 && waited < 5000) begin
      @(posedge clk);
      waited++;
    end
    repeat (16) @(posedge clk);
    if (sb.ticks_due.size() != 0)
      $display("%0t ns: %0d expected result beats never arrived", $time, sb.ticks_due.size());
    if (sb.errors == 0 && sb.ticks_due.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("%0t ns: timeout", $time);
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
